/* sv/b64d_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the character classifier for the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0] CharPad = 8'h3D;

  typedef enum logic [1:0] {
    PH_RUN  = 2'd0,
    PH_DONE = 2'd1,
    PH_BAD  = 2'd2
  } b64d_phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } b64d_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic       success;
    logic       last;
  } b64d_out_t;

  // one request's worth of results: up to three bytes and an optional status
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] nbytes;
    logic       has_status;
    logic       success;
  } b64d_rec_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } b64d_sextet_t;

  function automatic b64d_sextet_t sextet_of(input logic [7:0] c);
    b64d_sextet_t r;
    logic [7:0]   t;
    r = '0;
    t = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r = '{valid: 1'b1, value: t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
      r = '{valid: 1'b1, value: t[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
      r = '{valid: 1'b1, value: t[5:0]};
    end else if (c == 8'h2B) begin
      r = '{valid: 1'b1, value: 6'h3E};
    end else if (c == 8'h2F) begin
      r = '{valid: 1'b1, value: 6'h3F};
    end else if (c == CharPad) begin
      r = '{valid: 1'b1, value: 6'h00};
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0B ||
           c == 8'h0C || c == 8'h0D;
  endfunction

endpackage

/* sv/b64d_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks the current group and stream phase, and issues
// one result record per well-formed completed group and per end of input.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  input  logic                full_i,
  input  b64d_pkg::b64d_in_t  item_i,
  output logic                rec_push_o,
  output b64d_pkg::b64d_rec_t rec_o
);
  import b64d_pkg::*;

  logic [5:0]   s0_q, s0_d;
  logic [5:0]   s1_q, s1_d;
  logic [6:0]   s2_q, s2_d;
  logic [1:0]   count_q, count_d;
  b64d_phase_e  phase_q, phase_d;

  logic         accept;
  logic         pad;
  logic         s2pad;
  b64d_sextet_t sx;

  assign accept = push && !full_i;
  assign pad    = item_i.char_code == CharPad;
  assign s2pad  = s2_q[6];
  assign sx     = sextet_of(item_i.char_code);

  always_comb begin
    s0_d       = s0_q;
    s1_d       = s1_q;
    s2_d       = s2_q;
    count_d    = count_q;
    phase_d    = phase_q;
    rec_push_o = 1'b0;
    rec_o      = '0;
    rec_o.b0   = {s0_q, s1_q[5:4]};
    rec_o.b1   = {s1_q[3:0], s2_q[5:2]};
    rec_o.b2   = {s2_q[1:0], sx.value};
    if (accept) begin
      if (!item_i.end_of_input) begin
        if (phase_q == PH_RUN && !is_blank(item_i.char_code)) begin
          if (!sx.valid || (pad && count_q < 2'd2)) begin
            phase_d = PH_BAD;
            count_d = '0;
          end else if (count_q != 2'd3) begin
            unique case (count_q)
              2'd0: s0_d = sx.value;
              2'd1: s1_d = sx.value;
              default: s2_d = {pad, sx.value};
            endcase
            count_d = count_q + 2'd1;
          end else begin
            count_d = '0;
            if (s2pad && !pad) begin
              phase_d = PH_BAD;
            end else begin
              rec_push_o = 1'b1;
              if (s2pad) begin
                rec_o.nbytes = 2'd1;
              end else if (pad) begin
                rec_o.nbytes = 2'd2;
              end else begin
                rec_o.nbytes = 2'd3;
              end
              if (pad || s2pad) begin
                phase_d = PH_DONE;
              end
              s0_d = '0;
              s1_d = '0;
              s2_d = '0;
            end
          end
        end
      end else begin
        rec_push_o       = 1'b1;
        rec_o.has_status = 1'b1;
        rec_o.b2         = '0;
        if (phase_q != PH_RUN) begin
          rec_o.success = phase_q == PH_DONE;
        end else begin
          unique case (count_q)
            2'd0: rec_o.success = 1'b1;
            2'd1: rec_o.success = 1'b0;
            2'd2: begin
              rec_o.success = 1'b1;
              rec_o.nbytes  = 2'd1;
            end
            default: begin
              rec_o.success = 1'b1;
              rec_o.nbytes  = s2pad ? 2'd1 : 2'd2;
            end
          endcase
        end
        s0_d    = '0;
        s1_d    = '0;
        s2_d    = '0;
        count_d = '0;
        phase_d = PH_RUN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q    <= '0;
      s1_q    <= '0;
      s2_q    <= '0;
      count_q <= '0;
      phase_q <= PH_RUN;
    end else begin
      s0_q    <= s0_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      count_q <= count_d;
      phase_q <= phase_d;
    end
  end

endmodule

/* sv/b64d_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_fifo
// Short queue of result records between the front and back parts.
// ----------------------------------------------------------------------------
module b64d_fifo #(
  parameter int unsigned Depth = b64d_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64d_pkg::b64d_rec_t wdata_i,
  output logic                full_o,
  input  logic                pop_i,
  output b64d_pkg::b64d_rec_t rdata_o,
  output logic                empty_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  b64d_rec_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = cnt_q == CntFull;
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/b64d_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back
// Unpacks result records into single results, one a cycle unless the output
// is held, into an output register.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64d_pkg::b64d_rec_t rec_i,
  input  logic                rec_empty_i,
  output logic                rec_pop_o,
  output b64d_pkg::b64d_out_t result_o,
  output logic                empty,
  input  logic                pop
);
  import b64d_pkg::*;

  b64d_rec_t  cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [1:0] idx_q, idx_d;
  b64d_out_t  out_q, out_d;
  logic       out_valid_q, out_valid_d;

  logic       advance;
  logic       at_last;
  logic [1:0] total;
  b64d_out_t  res;

  assign total     = cur_q.nbytes + {1'b0, cur_q.has_status};
  assign at_last   = idx_q == total - 2'd1;
  assign advance   = cur_valid_q && (!out_valid_q || pop);
  assign rec_pop_o = (!cur_valid_q || (advance && at_last)) && !rec_empty_i;
  assign empty     = !out_valid_q;
  assign result_o  = out_q;

  always_comb begin
    res = '0;
    if (idx_q < cur_q.nbytes) begin
      unique case (idx_q)
        2'd0:    res.out_byte = cur_q.b0;
        2'd1:    res.out_byte = cur_q.b1;
        default: res.out_byte = cur_q.b2;
      endcase
    end else begin
      res.is_status = 1'b1;
      res.success   = cur_q.success;
      res.last      = 1'b1;
    end
  end

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_d       = res;
      out_valid_d = 1'b1;
      idx_d       = idx_q + 2'd1;
      if (at_last) begin
        cur_valid_d = 1'b0;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
    if (rec_pop_o) begin
      cur_d       = rec_i;
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* sv/base64_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder with whitespace skipping and a final status.
// ----------------------------------------------------------------------------
// One character is taken per clock while full is low. A character that
// completes a well-formed group, and every end-of-input request, issues a
// record into a queue of FifoDepth entries; the back part turns each record
// into one to three results at one result per clock unless the output is
// held, so the output side sets the sustained rate and full rises only when
// the record queue fills. Results pass the queue and the back part's record
// and output registers. After end of input a new string is taken at once.
module base64_stream_decoder #(
  parameter int unsigned FifoDepth = b64d_pkg::FifoDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  b64d_pkg::b64d_in_t  item_i,
  output logic                empty,
  input  logic                pop,
  output b64d_pkg::b64d_out_t result_o
);
  import b64d_pkg::*;

  logic      rec_push;
  b64d_rec_t rec_w;
  logic      mid_full;
  logic      mid_pop;
  logic      mid_empty;
  b64d_rec_t mid_rec;

  assign full = mid_full;

  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full_i     (mid_full),
    .item_i     (item_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_w)
  );

  b64d_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_w),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .rdata_o (mid_rec),
    .empty_o (mid_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (mid_rec),
    .rec_empty_i (mid_empty),
    .rec_pop_o   (mid_pop),
    .result_o    (result_o),
    .empty       (empty),
    .pop         (pop)
  );

`ifndef ASSERT_OFF
  a_status_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.is_status) |-> (result_o.last && result_o.out_byte == 8'd0))
    else $error("status result malformed");

  a_data_form : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !result_o.is_status) |-> (!result_o.success && !result_o.last))
    else $error("data result carries status bits");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> !mid_full)
    else $error("record pushed into full queue");

  a_record_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push |-> (rec_w.has_status ? rec_w.nbytes != 2'd3 : rec_w.nbytes != 2'd0))
    else $error("record result count out of range");
`endif

endmodule
